FILE: sv/pfe_pkg.sv
// Shared types, codes and constants of the postfix expression evaluator.
`default_nettype none

package pfe_pkg;

	localparam int STACK_DEPTH_DEFAULT = 128;
	localparam int DATA_W = 32;

	localparam logic [7:0] CHAR_ZERO  = 8'h30; // '0'
	localparam logic [7:0] CHAR_NINE  = 8'h39; // '9'
	localparam logic [7:0] CHAR_PLUS  = 8'h2B; // '+'
	localparam logic [7:0] CHAR_MINUS = 8'h2D; // '-'
	localparam logic [7:0] CHAR_STAR  = 8'h2A; // '*'
	localparam logic [7:0] CHAR_SLASH = 8'h2F; // '/'

	typedef struct packed {
		logic [7:0] character;
		logic       last_char;
	} char_item_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] value;
		logic                     status;
		logic                     overflow_seen;
		logic                     underflow_seen;
	} result_item_t;

	typedef enum logic [1:0] {
		OP_ADD,
		OP_SUB,
		OP_MUL,
		OP_DIV
	} alu_op_t;

	typedef struct packed {
		logic              start;
		alu_op_t           op;
		logic [DATA_W-1:0] a;
		logic [DATA_W-1:0] b;
	} alu_req_t;

	typedef struct packed {
		logic              done;
		logic [DATA_W-1:0] result;
	} alu_rsp_t;

	typedef enum logic [2:0] {
		AP_IDLE,
		AP_ABS_A,
		AP_ABS_B,
		AP_MUL,
		AP_DIV,
		AP_FIX
	} alu_phase_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_POP_L,
		ST_CALC,
		ST_WAIT,
		ST_PUSH,
		ST_FINISH,
		ST_EMIT
	} pfe_state_t;

	function automatic logic is_digit(input logic [7:0] ch);
		return (ch >= CHAR_ZERO) && (ch <= CHAR_NINE);
	endfunction

	function automatic logic is_operator(input logic [7:0] ch);
		return (ch == CHAR_PLUS) || (ch == CHAR_MINUS) || (ch == CHAR_STAR) ||
			(ch == CHAR_SLASH);
	endfunction

	function automatic alu_op_t char_to_op(input logic [7:0] ch);
		alu_op_t op;
		op = OP_ADD;
		case (ch)
			CHAR_MINUS: op = OP_SUB;
			CHAR_STAR:  op = OP_MUL;
			CHAR_SLASH: op = OP_DIV;
			default:    op = OP_ADD;
		endcase
		return op;
	endfunction

endpackage

`default_nettype wire

FILE: sv/pfe_stream_if.sv
// Valid/ready stream channel carrying one payload item per transfer.
`default_nettype none

interface pfe_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

`default_nettype wire

FILE: sv/pfe_alu.sv
// Iterative arithmetic unit: one shared adder does add, subtract, multiply and divide.
`default_nettype none

module pfe_alu (
	input  logic             clk,
	input  logic             arst_n,
	input  pfe_pkg::alu_req_t req,
	output pfe_pkg::alu_rsp_t rsp
);
	import pfe_pkg::*;

	alu_phase_t        phase_q;
	logic              done_q;
	logic [DATA_W-1:0] result_q;
	logic [4:0]        cnt_q;
	logic [DATA_W:0]   work_q;
	logic [DATA_W-1:0] opa_q;
	logic [DATA_W-1:0] opb_q;
	logic              neg_q;

	logic [DATA_W+1:0] add_a;
	logic [DATA_W+1:0] add_b;
	logic              add_cin;
	logic [DATA_W+1:0] sum;
	logic [DATA_W:0]   shifted;
	logic              ge;

	assign shifted = {work_q[DATA_W-1:0], opa_q[DATA_W-1]};

	// Operand select for the single shared adder
	always_comb begin
		add_a   = '0;
		add_b   = '0;
		add_cin = 1'b0;
		unique case (phase_q)
			AP_IDLE: begin
				add_a = {2'b00, req.a};
				if (req.op == OP_SUB) begin
					add_b   = ~{2'b00, req.b};
					add_cin = 1'b1;
				end else begin
					add_b = {2'b00, req.b};
				end
			end
			AP_ABS_A: begin
				add_a   = {2'b00, ~opa_q};
				add_cin = 1'b1;
			end
			AP_ABS_B: begin
				add_a   = {2'b00, ~opb_q};
				add_cin = 1'b1;
			end
			AP_MUL: begin
				add_a = {2'b00, work_q[DATA_W-1:0]};
				add_b = opb_q[0] ? {2'b00, opa_q} : '0;
			end
			AP_DIV: begin
				add_a   = {1'b0, shifted};
				add_b   = ~{2'b00, opb_q};
				add_cin = 1'b1;
			end
			AP_FIX: begin
				add_a   = {2'b00, ~opa_q};
				add_cin = 1'b1;
			end
			default: begin
				add_a = '0;
			end
		endcase
	end

	assign sum = add_a + add_b + {{(DATA_W+1){1'b0}}, add_cin};
	assign ge  = ~sum[DATA_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= AP_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (phase_q)
				AP_IDLE: begin
					if (req.start) begin
						unique case (req.op)
							OP_ADD, OP_SUB: done_q <= 1'b1;
							OP_MUL:         phase_q <= AP_MUL;
							OP_DIV:         phase_q <= AP_ABS_A;
						endcase
					end
				end
				AP_ABS_A: phase_q <= AP_ABS_B;
				AP_ABS_B: phase_q <= AP_DIV;
				AP_MUL: begin
					if (cnt_q == '0) begin
						phase_q <= AP_IDLE;
						done_q  <= 1'b1;
					end
				end
				AP_DIV: begin
					if (cnt_q == '0) begin
						phase_q <= AP_FIX;
					end
				end
				AP_FIX: begin
					phase_q <= AP_IDLE;
					done_q  <= 1'b1;
				end
				default: phase_q <= AP_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (phase_q)
			AP_IDLE: begin
				if (req.start) begin
					opa_q  <= req.a;
					opb_q  <= req.b;
					work_q <= '0;
					cnt_q  <= 5'd31;
					neg_q  <= req.a[DATA_W-1] ^ req.b[DATA_W-1];
					if (req.op == OP_ADD || req.op == OP_SUB) begin
						result_q <= sum[DATA_W-1:0];
					end
				end
			end
			AP_ABS_A: begin
				if (opa_q[DATA_W-1]) begin
					opa_q <= sum[DATA_W-1:0];
				end
			end
			AP_ABS_B: begin
				if (opb_q[DATA_W-1]) begin
					opb_q <= sum[DATA_W-1:0];
				end
			end
			AP_MUL: begin
				work_q <= {1'b0, sum[DATA_W-1:0]};
				opa_q  <= {opa_q[DATA_W-2:0], 1'b0};
				opb_q  <= {1'b0, opb_q[DATA_W-1:1]};
				cnt_q  <= cnt_q - 5'd1;
				if (cnt_q == '0) begin
					result_q <= sum[DATA_W-1:0];
				end
			end
			AP_DIV: begin
				// restoring step: keep the trial difference when it did not borrow
				work_q <= ge ? sum[DATA_W:0] : shifted;
				opa_q  <= {opa_q[DATA_W-2:0], ge};
				cnt_q  <= cnt_q - 5'd1;
			end
			AP_FIX: begin
				result_q <= neg_q ? sum[DATA_W-1:0] : opa_q;
			end
			default: begin
				cnt_q <= cnt_q;
			end
		endcase
	end

	assign rsp.done   = done_q;
	assign rsp.result = result_q;

`ifndef NO_ASSERTIONS
	a_start_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> phase_q == AP_IDLE)
		else $error("pfe_alu: start while busy");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done |=> !rsp.done)
		else $error("pfe_alu: done held longer than one cycle");

	a_fix_finishes: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == AP_FIX |=> rsp.done && phase_q == AP_IDLE)
		else $error("pfe_alu: sign fix did not finish the divide");
`endif

endmodule

`default_nettype wire

FILE: sv/postfix_expression_evaluator.sv
// Top level: postfix expression evaluator with stack memory and sequencer.
// Characters: a new character is taken only in ST_IDLE, once the previous one is done; * and /
//   take longest, as the iterative multiply/divide in pfe_alu sets the worst case.
// A last character passes through ST_EMIT to load the result register, and waits there while it is full.
// The result register lets the next character transfer while a result still waits.
// Reset: arst_n clears the sequencer, stack count and flags at once; the stack memory is
//   left unreset and needs no clearing pass, since only entries below the count are used.
`default_nettype none

module postfix_expression_evaluator #(
	parameter int STACK_DEPTH = pfe_pkg::STACK_DEPTH_DEFAULT
) (
	input  logic         clk,
	input  logic         arst_n,
	pfe_stream_if.sink   item,
	pfe_stream_if.source result
);
	import pfe_pkg::*;

	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int AW = $clog2(STACK_DEPTH);

	// sequencer and control state
	pfe_state_t state_q, state_d;
	logic [CW-1:0] count_q;
	logic          div_fault_q;
	logic          overflow_q;
	logic          underflow_q;
	logic          pop_empty_q;

	// captured character and operands
	logic [7:0]        char_q;
	logic              last_q;
	logic [DATA_W-1:0] right_q;

	// stack memory
	logic [DATA_W-1:0] stack_mem [STACK_DEPTH];
	logic [DATA_W-1:0] rd_data_q;
	logic [CW-1:0]     count_m1;
	logic [AW-1:0]     rd_addr;
	logic [AW-1:0]     wr_addr;
	logic              mem_we;
	logic [DATA_W-1:0] mem_wdata;

	// result register
	logic         res_valid_q;
	result_item_t res_q;

	logic     full;
	logic     empty;
	logic     out_free;
	logic     out_load;
	logic     div_zero;
	logic [DATA_W-1:0] left_val;
	alu_op_t  op;
	alu_req_t alu_req;
	alu_rsp_t alu_rsp;

	assign full     = (count_q == CW'(STACK_DEPTH));
	assign empty    = (count_q == '0);
	assign count_m1 = count_q - CW'(1);
	// top of stack is always read; a pop uses it only when the stack is not empty
	assign rd_addr  = count_m1[AW-1:0];
	assign wr_addr  = count_q[AW-1:0];
	assign out_free = !res_valid_q || result.ready;
	assign op       = char_to_op(char_q);
	assign div_zero = (op == OP_DIV) && (right_q == '0);
	// left operand arrives from the read issued during the left pop
	assign left_val = pop_empty_q ? '0 : rd_data_q;

	pfe_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.rsp    (alu_rsp)
	);

	// Next-state logic
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (item.valid) begin
					state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				// after a divide fault everything up to the last character is dropped
				if (div_fault_q || !is_operator(char_q)) begin
					state_d = ST_FINISH;
				end else begin
					state_d = ST_POP_L;
				end
			end
			ST_POP_L: state_d = ST_CALC;
			ST_CALC: begin
				state_d = div_zero ? ST_FINISH : ST_WAIT;
			end
			ST_WAIT: begin
				if (alu_rsp.done) begin
					state_d = ST_PUSH;
				end
			end
			ST_PUSH:   state_d = ST_FINISH;
			ST_FINISH: state_d = last_q ? ST_EMIT : ST_IDLE;
			ST_EMIT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Control outputs of the sequencer
	always_comb begin
		item.ready    = 1'b0;
		mem_we        = 1'b0;
		mem_wdata     = alu_rsp.result;
		out_load      = 1'b0;
		alu_req.start = 1'b0;
		alu_req.op    = op;
		alu_req.a     = left_val;
		alu_req.b     = right_q;
		unique case (state_q)
			ST_IDLE: item.ready = 1'b1;
			ST_DECODE: begin
				// digit value is the low nibble of '0'..'9'
				mem_wdata = {{(DATA_W-4){1'b0}}, char_q[3:0]};
				mem_we    = !div_fault_q && is_digit(char_q) && !full;
			end
			ST_CALC: alu_req.start = !div_zero;
			ST_PUSH: mem_we = !full;
			ST_EMIT: out_load = out_free;
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	// Sequencer, stack count and sticky flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			div_fault_q <= 1'b0;
			overflow_q  <= 1'b0;
			underflow_q <= 1'b0;
			pop_empty_q <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (result.ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_DECODE: begin
					if (!div_fault_q && is_digit(char_q)) begin
						if (full) begin
							overflow_q <= 1'b1;
						end else begin
							count_q <= count_q + CW'(1);
						end
					end else if (!div_fault_q && is_operator(char_q)) begin
						// pop the right operand
						pop_empty_q <= empty;
						if (empty) begin
							underflow_q <= 1'b1;
						end else begin
							count_q <= count_m1;
						end
					end
				end
				ST_POP_L: begin
					// pop the left operand
					pop_empty_q <= empty;
					if (empty) begin
						underflow_q <= 1'b1;
					end else begin
						count_q <= count_m1;
					end
				end
				ST_CALC: begin
					if (div_zero) begin
						div_fault_q <= 1'b1;
					end
				end
				ST_PUSH: begin
					if (full) begin
						overflow_q <= 1'b1;
					end else begin
						count_q <= count_q + CW'(1);
					end
				end
				ST_EMIT: begin
					// hand over the result and clear for the next expression
					if (out_free) begin
						res_valid_q <= 1'b1;
						count_q     <= '0;
						div_fault_q <= 1'b0;
						overflow_q  <= 1'b0;
						underflow_q <= 1'b0;
					end
				end
				default: begin
					count_q <= count_q;
				end
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			char_q <= item.payload.character;
			last_q <= item.payload.last_char;
		end
		if (state_q == ST_POP_L) begin
			right_q <= pop_empty_q ? '0 : rd_data_q;
		end
		if (out_load) begin
			res_q.value          <= (div_fault_q || empty) ? '0 : rd_data_q;
			res_q.status         <= div_fault_q;
			res_q.overflow_seen  <= overflow_q;
			res_q.underflow_seen <= underflow_q;
		end
	end

	// Stack memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			stack_mem[wr_addr] <= mem_wdata;
		end
		rd_data_q <= stack_mem[rd_addr];
	end

	assign result.valid   = res_valid_q;
	assign result.payload = res_q;

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(STACK_DEPTH))
		else $error("pfe: stack count beyond depth");

	a_no_write_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> !full)
		else $error("pfe: stack write on a full stack");

	a_fault_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		div_fault_q && state_q != ST_EMIT |=> div_fault_q)
		else $error("pfe: divide fault dropped before the result");

	a_emit_clears: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> result.valid && count_q == '0 && !div_fault_q)
		else $error("pfe: result load did not clear the expression state");
`endif

endmodule

`default_nettype wire
